// File: rtl/cftc_pkg.sv
// Package for the CSV field type classifier.
// Holds sizes, character codes, the kind encoding and the field event record.
// No dependencies.
package cftc_pkg;

	localparam int MAX_COLUMNS   = 64;
	localparam int MAX_FIELD_LEN = 256;
	localparam int COL_W         = $clog2(MAX_COLUMNS);
	localparam int CNT_W         = $clog2(MAX_FIELD_LEN + 1);
	localparam int CFG_W         = 7;
	localparam int VAL_W         = 32;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		KIND_INT    = 2'd0,
		KIND_FLOAT  = 2'd1,
		KIND_STRING = 2'd2,
		KIND_UNSET  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		kind_t            kind;
		logic [VAL_W-1:0] mag;
		logic             neg;
		logic             clip;
		logic             row_end;
		logic             table_end;
		logic             restart;
	} event_t;

endpackage

// File: rtl/cftc_if.sv
// Channel interfaces for the CSV field type classifier.
// Byte input, field result and configuration write channels; no dependencies.
interface cftc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       restart;
	modport source(output valid, char_code, restart, input ready);
	modport sink(input valid, char_code, restart, output ready);
endinterface

interface cftc_out_if;
	logic               valid;
	logic               ready;
	logic        [5:0]  column_index;
	logic        [1:0]  field_kind;
	logic        [1:0]  column_kind;
	logic signed [31:0] int_value;
	logic               value_clipped;
	logic               row_end;
	logic               table_end;
	modport source(output valid, column_index, field_kind, column_kind, int_value,
		value_clipped, row_end, table_end, input ready);
	modport sink(input valid, column_index, field_kind, column_kind, int_value,
		value_clipped, row_end, table_end, output ready);
endinterface

interface cftc_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] column_count;
	modport source(output valid, column_count, input ready);
	modport sink(input valid, column_count, output ready);
endinterface

// File: rtl/cftc_front.sv
// Front end: per-byte quote tracking, field splitting, classification and value.
// Emits one event per ended field, table end or restart. Uses cftc_pkg and cftc_in_if.
module cftc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	cftc_in_if.sink                        data,
	input  logic [cftc_pkg::CFG_W-1:0]     column_count,
	input  logic                           q_full,
	output logic                           push,
	output cftc_pkg::event_t               ev
);

	logic                          quote_q, quote_d;
	cftc_pkg::kind_t               kind_q, kind_d;
	logic [cftc_pkg::CNT_W-1:0]    cnt_q, cnt_d;
	logic [cftc_pkg::COL_W-1:0]    col_q, col_d;
	logic [cftc_pkg::VAL_W-1:0]    acc_q, acc_d;
	logic                          neg_q, neg_d;
	logic                          clip_q, clip_d;
	logic                          fin_q, fin_d;

	logic                          accept;
	logic [7:0]                    c;
	logic                          is_sep, is_nl, digit, len_end, last_col;
	logic [cftc_pkg::COL_W-1:0]    last_idx;
	logic [cftc_pkg::VAL_W+3:0]    prod, limit;
	cftc_pkg::kind_t               kind_u;
	logic                          neg_u, clip_u;
	logic [cftc_pkg::VAL_W-1:0]    acc_u;

	assign data.ready = !q_full;
	assign accept     = data.valid && data.ready;
	assign c          = data.char_code;

	always_comb begin
		if (column_count == '0) begin
			last_idx = '0;
		end else if (column_count > cftc_pkg::CFG_W'(cftc_pkg::MAX_COLUMNS)) begin
			last_idx = cftc_pkg::COL_W'(cftc_pkg::MAX_COLUMNS - 1);
		end else begin
			last_idx = cftc_pkg::COL_W'(column_count - 1'b1);
		end
	end

	assign last_col = col_q >= last_idx;
	assign is_sep   = (c == cftc_pkg::CH_NUL) || (c == cftc_pkg::CH_COMMA && !quote_q);
	assign is_nl    = (c == cftc_pkg::CH_LF) || (c == cftc_pkg::CH_CR);
	assign digit    = (c >= cftc_pkg::CH_ZERO) && (c <= cftc_pkg::CH_NINE);
	assign len_end  = cnt_q == cftc_pkg::CNT_W'(cftc_pkg::MAX_FIELD_LEN - 1);

	// classify the byte and accumulate the decimal value
	always_comb begin
		kind_u = kind_q;
		neg_u  = neg_q;
		clip_u = clip_q;
		acc_u  = acc_q;
		if (kind_q == cftc_pkg::KIND_INT) begin
			if (c == cftc_pkg::CH_DOT) begin
				kind_u = cftc_pkg::KIND_FLOAT;
			end else if (!digit) begin
				if (c == cftc_pkg::CH_MINUS && cnt_q == '0) begin
					neg_u = 1'b1;
				end else begin
					kind_u = cftc_pkg::KIND_STRING;
				end
			end
		end else if (kind_q == cftc_pkg::KIND_FLOAT && !digit) begin
			kind_u = cftc_pkg::KIND_STRING;
		end
		prod  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
			+ (cftc_pkg::VAL_W+4)'(c - cftc_pkg::CH_ZERO);
		limit = neg_u ? (cftc_pkg::VAL_W+4)'(36'h080000000)
			: (cftc_pkg::VAL_W+4)'(36'h07FFFFFFF);
		if (kind_u == cftc_pkg::KIND_INT && digit) begin
			if (prod > limit) begin
				acc_u  = limit[cftc_pkg::VAL_W-1:0];
				clip_u = 1'b1;
			end else begin
				acc_u = prod[cftc_pkg::VAL_W-1:0];
			end
		end
	end

	always_comb begin
		quote_d = quote_q;
		kind_d  = kind_q;
		cnt_d   = cnt_q;
		col_d   = col_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		clip_d  = clip_q;
		fin_d   = fin_q;
		push    = 1'b0;
		ev      = '0;
		ev.kind = kind_q;
		ev.col  = col_q;
		ev.mag  = acc_q;
		ev.neg  = neg_q;
		ev.clip = clip_q;
		if (accept) begin
			if (data.restart) begin
				push       = 1'b1;
				ev.restart = 1'b1;
				col_d      = '0;
				fin_d      = 1'b0;
			end else if (!fin_q) begin
				if (is_sep) begin
					push       = 1'b1;
					ev.row_end = last_col;
					col_d      = last_col ? '0 : col_q + 1'b1;
				end else if (is_nl) begin
					push = 1'b1;
					if (col_q == '0) begin
						ev           = '0;
						ev.table_end = 1'b1;
						fin_d        = 1'b1;
					end else begin
						ev.row_end = 1'b1;
						col_d      = '0;
					end
				end else begin
					quote_d = quote_q ^ (c == cftc_pkg::CH_QUOTE);
					kind_d  = kind_u;
					neg_d   = neg_u;
					clip_d  = clip_u;
					acc_d   = acc_u;
					cnt_d   = cnt_q + 1'b1;
					if (len_end) begin
						push       = 1'b1;
						ev.kind    = kind_u;
						ev.mag     = acc_u;
						ev.neg     = neg_u;
						ev.clip    = clip_u;
						ev.row_end = last_col;
						col_d      = last_col ? '0 : col_q + 1'b1;
					end
				end
			end
			// clear the field on any end
			if (data.restart || (!fin_q && (is_sep || is_nl || len_end))) begin
				quote_d = 1'b0;
				kind_d  = cftc_pkg::KIND_INT;
				cnt_d   = '0;
				acc_d   = '0;
				neg_d   = 1'b0;
				clip_d  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= 1'b0;
			kind_q  <= cftc_pkg::KIND_INT;
			cnt_q   <= '0;
			col_q   <= '0;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			clip_q  <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			quote_q <= quote_d;
			kind_q  <= kind_d;
			cnt_q   <= cnt_d;
			col_q   <= col_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			clip_q  <= clip_d;
			fin_q   <= fin_d;
		end
	end

endmodule

// File: rtl/cftc_queue.sv
// Two-entry event queue between the front end and the back end.
// Uses cftc_pkg for the event record.
module cftc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cftc_pkg::event_t push_ev,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output cftc_pkg::event_t head
);

	cftc_pkg::event_t slot_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: rtl/cftc_back.sv
// Back end: column type table merge and result register.
// Table in a memory with per-column valid bits. Uses cftc_pkg and cftc_out_if.
module cftc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  cftc_pkg::event_t q_head,
	output logic             q_pop,
	cftc_out_if.source       result
);

	cftc_pkg::kind_t                    kind_mem [cftc_pkg::MAX_COLUMNS];
	logic [cftc_pkg::MAX_COLUMNS-1:0]   tvld_q;

	logic             vld_s1;
	cftc_pkg::event_t ev_s1;
	cftc_pkg::kind_t  rd_s1;
	logic             byp_s1;
	cftc_pkg::kind_t  bypk_s1;

	logic             out_free, go, load, wr, out_load;
	cftc_pkg::kind_t  prev, merged;

	assign out_free = !result.valid || result.ready;
	assign go       = vld_s1 && (ev_s1.restart || out_free);
	assign load     = q_valid && (!vld_s1 || go);
	assign q_pop    = load;
	assign wr       = go && !ev_s1.restart && !ev_s1.table_end;
	assign out_load = go && !ev_s1.restart;

	always_comb begin
		if (byp_s1) begin
			prev = bypk_s1;
		end else if (tvld_q[ev_s1.col]) begin
			prev = rd_s1;
		end else begin
			prev = cftc_pkg::KIND_UNSET;
		end
		if (prev == cftc_pkg::KIND_UNSET) begin
			merged = ev_s1.kind;
		end else if (ev_s1.kind == cftc_pkg::KIND_STRING) begin
			merged = cftc_pkg::KIND_STRING;
		end else begin
			merged = prev;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			kind_mem[ev_s1.col] <= merged;
		end
		if (load) begin
			rd_s1   <= kind_mem[q_head.col];
			ev_s1   <= q_head;
			byp_s1  <= wr && (q_head.col == ev_s1.col);
			bypk_s1 <= merged;
		end
		if (out_load) begin
			result.table_end <= ev_s1.table_end;
			if (ev_s1.table_end) begin
				result.column_index  <= '0;
				result.field_kind    <= '0;
				result.column_kind   <= '0;
				result.int_value     <= '0;
				result.value_clipped <= 1'b0;
				result.row_end       <= 1'b0;
			end else begin
				result.column_index <= ev_s1.col;
				result.field_kind   <= ev_s1.kind;
				result.column_kind  <= merged;
				result.row_end      <= ev_s1.row_end;
				if (ev_s1.kind == cftc_pkg::KIND_INT) begin
					result.int_value     <= ev_s1.neg ? -ev_s1.mag : ev_s1.mag;
					result.value_clipped <= ev_s1.clip;
				end else begin
					result.int_value     <= '0;
					result.value_clipped <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			tvld_q       <= '0;
			result.valid <= 1'b0;
		end else begin
			if (load) begin
				vld_s1 <= 1'b1;
			end else if (go) begin
				vld_s1 <= 1'b0;
			end
			if (go && ev_s1.restart) begin
				tvld_q <= '0;
			end else if (wr) begin
				tvld_q[ev_s1.col] <= 1'b1;
			end
			if (out_load) begin
				result.valid <= 1'b1;
			end else if (result.ready) begin
				result.valid <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/csv_field_type_classifier_core.sv
// CSV field type classifier, top level: column count register, front end,
// event queue and back end. Uses cftc_pkg, cftc_if, cftc_front, cftc_queue, cftc_back.
//
// Takes one CSV data byte per cycle while the event queue is not full; the
// per-byte classifier and saturating x10 accumulate are combinational in the
// front end. A field result goes through the queue, the table read stage and
// the result register after the byte that ends it. The column type table, a
// 64-entry memory, has a registered read, a later write and a one-entry
// bypass; it is cleared at reset or restart through per-column valid bits, so
// no clearing pass is needed. Write the column count only while idle.
module csv_field_type_classifier_core (
	input  logic        clk,
	input  logic        arst_n,
	cftc_in_if.sink     data,
	cftc_out_if.source  result,
	cftc_cfg_if.sink    cfg
);

	logic [cftc_pkg::CFG_W-1:0] column_count_q;
	logic                       push, q_full, q_valid, q_pop;
	cftc_pkg::event_t           push_ev, q_head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= cftc_pkg::CFG_W'(1);
		end else if (cfg.valid) begin
			column_count_q <= cfg.column_count;
		end
	end

	cftc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.data         (data),
		.column_count (column_count_q),
		.q_full       (q_full),
		.push         (push),
		.ev           (push_ev)
	);

	cftc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ev   (push_ev),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	cftc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.result  (result)
	);

	a_table_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.table_end |->
			result.column_index == '0 && result.int_value == '0 && !result.row_end)
		else $error("table end result carries field data");

	a_non_int_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.field_kind != cftc_pkg::KIND_INT |->
			result.int_value == '0 && !result.value_clipped)
		else $error("non-int field carries a value");

	a_merge_string: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.table_end && result.field_kind == cftc_pkg::KIND_STRING |->
			result.column_kind == cftc_pkg::KIND_STRING)
		else $error("string field did not make the column string");

endmodule
